@@ rtl/select_spec_syntax_check_top_assert.svh @@
// ----------------------------------------------------------------------------
// select_spec_syntax_check_top_assert.svh
// assertion macros used by the checker file of the selection string checker
// ----------------------------------------------------------------------------
`ifndef SELECT_SPEC_SYNTAX_CHECK_TOP_ASSERT_SVH
`define SELECT_SPEC_SYNTAX_CHECK_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SSSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sssc_pkg.sv @@
// ----------------------------------------------------------------------------
// sssc_pkg
// types and constants of the resource selection string syntax checker
// ----------------------------------------------------------------------------
package sssc_pkg;

   // stream word widths
   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_TDATA_W = 8;

   // bytes that steer the grammar
   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   // parser phases, one-hot
   typedef enum logic [8:0] {
      PH_LEAD       = 9'b000000001,
      PH_CHUNK      = 9'b000000010,
      PH_MULT       = 9'b000000100,
      PH_NAME_START = 9'b000001000,
      PH_NAME       = 9'b000010000,
      PH_VAL_FIRST  = 9'b000100000,
      PH_VAL        = 9'b001000000,
      PH_QUOTED     = 9'b010000000,
      PH_ERROR      = 9'b100000000
   } phase_type;

   // outcome of one byte step
   typedef struct packed {
      phase_type phase;
      logic      quote_dbl;
      logic      accepted;
   } step_type;

endpackage

@@ rtl/select_spec_syntax_check_top.sv @@
// ----------------------------------------------------------------------------
// select_spec_syntax_check_top
// streaming syntax checker for resource selection strings
// ----------------------------------------------------------------------------
// Takes one string byte per clock on the req_ stream and, for every 0 byte
// that ends a string, returns one word on the rsp_ stream whose bit 0 is 1
// if the string was well formed and 0 if it was rejected; other bytes give
// no result. The sustained rate is one byte per cycle, set by the single
// parser phase register that every byte updates. A byte lands in an input
// register and is parsed from there, and as an end byte leaves it, its
// verdict is written into the result register. The result register lets
// bytes keep flowing while a verdict waits; only an end byte that meets a
// full, stalled result register holds the input.
// ----------------------------------------------------------------------------
module select_spec_syntax_check_top (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sssc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] text_byte
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sssc_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // [0] accepted, [7:1] zero
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // parser state
   sssc_pkg::phase_type phase_ff, phase_in;
   logic                quote_dbl_ff, quote_dbl_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic accepted_ff, accepted_in;

   logic               in_is_end;
   logic               consume;
   sssc_pkg::step_type step;

   // byte step logic
   sssc_phase_step u_step (
      .phase     (phase_ff),
      .quote_dbl (quote_dbl_ff),
      .text_byte (in_byte_ff),
      .step      (step)
   );

   // handshake: an end byte needs room in the result register
   assign in_is_end  = (in_byte_ff == sssc_pkg::CH_END);
   assign consume    = in_valid_ff && (!in_is_end || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;

   // next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      phase_in     = phase_ff;
      quote_dbl_in = quote_dbl_ff;
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (consume) begin
         in_valid_in  = 1'b0;
         phase_in     = step.phase;
         quote_dbl_in = step.quote_dbl;
         if (in_is_end) begin
            rsp_valid_in = 1'b1;
            accepted_in  = step.accepted;
         end
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata[7:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= sssc_pkg::PH_LEAD;
         quote_dbl_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         quote_dbl_ff <= quote_dbl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      accepted_ff <= accepted_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sssc_pkg::RSP_TDATA_W-1){1'b0}}, accepted_ff};

endmodule

@@ rtl/sssc_phase_step.sv @@
// ----------------------------------------------------------------------------
// sssc_phase_step
// next-phase logic of the selection string parser for one byte
// ----------------------------------------------------------------------------
module sssc_phase_step (
   input  sssc_pkg::phase_type phase,
   input  logic                quote_dbl,
   input  logic [7:0]          text_byte,
   output sssc_pkg::step_type  step
);

   // c locale character classes
   logic is_digit, is_alpha, is_alnum, is_space, is_print, is_quote;

   assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
   assign is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                     ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
   assign is_alnum = is_digit || is_alpha;
   assign is_space = (text_byte == 8'h20) ||
                     ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
   assign is_print = (text_byte >= 8'h20) && (text_byte <= 8'h7E);
   assign is_quote = (text_byte == sssc_pkg::CH_SQUOTE) ||
                     (text_byte == sssc_pkg::CH_DQUOTE);

   // start of a chunk: multiplier or name
   sssc_pkg::phase_type chunk_nx;
   always_comb begin
      priority if (is_digit) begin
         chunk_nx = sssc_pkg::PH_MULT;
      end else if (is_alpha) begin
         chunk_nx = sssc_pkg::PH_NAME;
      end else begin
         chunk_nx = sssc_pkg::PH_ERROR;
      end
   end

   // a byte inside a value
   sssc_pkg::phase_type value_nx;
   always_comb begin
      priority if (is_quote) begin
         value_nx = sssc_pkg::PH_QUOTED;
      end else if (text_byte == sssc_pkg::CH_COLON) begin
         value_nx = sssc_pkg::PH_NAME_START;
      end else if (text_byte == sssc_pkg::CH_PLUS) begin
         value_nx = sssc_pkg::PH_CHUNK;
      end else if (is_print) begin
         value_nx = sssc_pkg::PH_VAL;
      end else begin
         value_nx = sssc_pkg::PH_ERROR;
      end
   end

   // closing quote matches the opening one
   logic quote_close;
   assign quote_close = quote_dbl ? (text_byte == sssc_pkg::CH_DQUOTE)
                                  : (text_byte == sssc_pkg::CH_SQUOTE);

   // phase transition
   always_comb begin
      step.quote_dbl = quote_dbl;
      step.accepted  = (phase == sssc_pkg::PH_MULT) || (phase == sssc_pkg::PH_VAL);
      if (text_byte == sssc_pkg::CH_END) begin
         // end of string: back to the start for the next one
         step.phase     = sssc_pkg::PH_LEAD;
         step.quote_dbl = 1'b0;
      end else begin
         unique case (phase)
            sssc_pkg::PH_LEAD: begin
               step.phase = is_space ? sssc_pkg::PH_LEAD : chunk_nx;
            end
            sssc_pkg::PH_CHUNK: begin
               step.phase = chunk_nx;
            end
            sssc_pkg::PH_MULT: begin
               priority if (is_digit) begin
                  step.phase = sssc_pkg::PH_MULT;
               end else if (text_byte == sssc_pkg::CH_PLUS) begin
                  step.phase = sssc_pkg::PH_CHUNK;
               end else if (text_byte == sssc_pkg::CH_COLON) begin
                  step.phase = sssc_pkg::PH_NAME_START;
               end else begin
                  step.phase = sssc_pkg::PH_ERROR;
               end
            end
            sssc_pkg::PH_NAME_START: begin
               step.phase = is_alpha ? sssc_pkg::PH_NAME : sssc_pkg::PH_ERROR;
            end
            sssc_pkg::PH_NAME: begin
               priority if (is_alnum || (text_byte == sssc_pkg::CH_DASH) ||
                            (text_byte == sssc_pkg::CH_USCORE)) begin
                  step.phase = sssc_pkg::PH_NAME;
               end else if (text_byte == sssc_pkg::CH_EQUAL) begin
                  step.phase = sssc_pkg::PH_VAL_FIRST;
               end else begin
                  step.phase = sssc_pkg::PH_ERROR;
               end
            end
            sssc_pkg::PH_VAL_FIRST, sssc_pkg::PH_VAL: begin
               step.phase = value_nx;
               if (is_quote) begin
                  step.quote_dbl = (text_byte == sssc_pkg::CH_DQUOTE);
               end
            end
            sssc_pkg::PH_QUOTED: begin
               step.phase = quote_close ? sssc_pkg::PH_VAL : sssc_pkg::PH_QUOTED;
            end
            default: begin
               // error latch and any stray code
               step.phase = sssc_pkg::PH_ERROR;
            end
         endcase
      end
   end

endmodule

@@ rtl/sssc_checker.sv @@
// ----------------------------------------------------------------------------
// sssc_checker
// port-level checks on the selection string checker, bound to its top level
// ----------------------------------------------------------------------------
`include "select_spec_syntax_check_top_assert.svh"

module sssc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [sssc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sssc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled verdict stays put
   `SSSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // padding bits of the verdict word are zero
   `SSSC_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[sssc_pkg::RSP_TDATA_W-1:1] == '0, "response padding not zero")

   // a fresh verdict follows an end byte taken in through the input register
   `SSSC_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready && (req_tdata == sssc_pkg::CH_END), 2), "verdict without end byte")

   // with the response side empty the input never stalls
   `SSSC_ASSERT_NOW(a_req_free, clock, reset, !rsp_tvalid, req_tready, "input stalled with empty response")

endmodule

bind select_spec_syntax_check_top sssc_checker u_sssc_checker (.*);

@@ sim/select_spec_syntax_check_top_test.sv @@
// ----------------------------------------------------------------------------
// select_spec_syntax_check_top_test
// self-checking bench for the selection string syntax checker
// ----------------------------------------------------------------------------
// Feeds strings one byte per word on the req_ stream: a few hand-picked
// strings first, then mostly grammar-built strings with random content,
// some of them corrupted, plus raw noise. A scoreboard class tracks the
// parser phase of every accepted byte and keeps the verdicts still owed,
// which it compares with the words coming back on the rsp_ stream. The
// sender works in bursts, the receiver stalls on its own pattern and holds
// off twice for a long stretch so that the result path fills up.
// ----------------------------------------------------------------------------
module select_spec_syntax_check_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TARGET_BYTES = 900;
   localparam int HOLD_OFF     = 200;

   // verdict tracking: parser phase per accepted byte, verdicts still owed
   class verdict_scoreboard;
      sssc_pkg::phase_type phase;
      bit                  quote_dbl;
      bit                  owed_verdicts[$];
      int                  failures;
      int                  n_accepted;
      int                  n_rejected;

      function new();
         phase      = sssc_pkg::PH_LEAD;
         quote_dbl  = 1'b0;
         failures   = 0;
         n_accepted = 0;
         n_rejected = 0;
      endfunction

      static function bit is_digit(logic [7:0] c);
         return c >= 8'h30 && c <= 8'h39;
      endfunction

      static function bit is_alpha(logic [7:0] c);
         return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      endfunction

      static function bit is_space(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      // start of a chunk: multiplier or name
      static function sssc_pkg::phase_type chunk_next(logic [7:0] c);
         if (is_digit(c)) return sssc_pkg::PH_MULT;
         if (is_alpha(c)) return sssc_pkg::PH_NAME;
         return sssc_pkg::PH_ERROR;
      endfunction

      // value byte outside a quoted run
      function sssc_pkg::phase_type value_next(logic [7:0] c);
         if (c == sssc_pkg::CH_SQUOTE || c == sssc_pkg::CH_DQUOTE) begin
            quote_dbl = (c == sssc_pkg::CH_DQUOTE);
            return sssc_pkg::PH_QUOTED;
         end
         if (c == sssc_pkg::CH_COLON) return sssc_pkg::PH_NAME_START;
         if (c == sssc_pkg::CH_PLUS) return sssc_pkg::PH_CHUNK;
         if (c >= 8'h20 && c <= 8'h7E) return sssc_pkg::PH_VAL;
         return sssc_pkg::PH_ERROR;
      endfunction

      // advance the parser on one accepted byte
      function void note_byte(logic [7:0] c);
         sssc_pkg::phase_type nx;
         if (c == sssc_pkg::CH_END) begin
            owed_verdicts.push_back(phase == sssc_pkg::PH_MULT ||
                                    phase == sssc_pkg::PH_VAL);
            phase     = sssc_pkg::PH_LEAD;
            quote_dbl = 1'b0;
            return;
         end
         case (phase)
            sssc_pkg::PH_LEAD:
               nx = is_space(c) ? sssc_pkg::PH_LEAD : chunk_next(c);
            sssc_pkg::PH_CHUNK:
               nx = chunk_next(c);
            sssc_pkg::PH_MULT: begin
               if (is_digit(c))                  nx = sssc_pkg::PH_MULT;
               else if (c == sssc_pkg::CH_PLUS)  nx = sssc_pkg::PH_CHUNK;
               else if (c == sssc_pkg::CH_COLON) nx = sssc_pkg::PH_NAME_START;
               else                              nx = sssc_pkg::PH_ERROR;
            end
            sssc_pkg::PH_NAME_START:
               nx = is_alpha(c) ? sssc_pkg::PH_NAME : sssc_pkg::PH_ERROR;
            sssc_pkg::PH_NAME: begin
               if (is_digit(c) || is_alpha(c) || c == sssc_pkg::CH_DASH ||
                   c == sssc_pkg::CH_USCORE)
                  nx = sssc_pkg::PH_NAME;
               else if (c == sssc_pkg::CH_EQUAL)
                  nx = sssc_pkg::PH_VAL_FIRST;
               else
                  nx = sssc_pkg::PH_ERROR;
            end
            sssc_pkg::PH_VAL_FIRST, sssc_pkg::PH_VAL: nx = value_next(c);
            sssc_pkg::PH_QUOTED: begin
               if ((quote_dbl && c == sssc_pkg::CH_DQUOTE) ||
                   (!quote_dbl && c == sssc_pkg::CH_SQUOTE))
                  nx = sssc_pkg::PH_VAL;
               else
                  nx = sssc_pkg::PH_QUOTED;
            end
            default:       nx = sssc_pkg::PH_ERROR;
         endcase
         phase = nx;
      endfunction

      // compare one result word with the oldest owed verdict
      function void check_verdict(logic [7:0] word);
         bit exp_acc;
         if (owed_verdicts.size() == 0) begin
            $error("unexpected result word %h with no verdict owed", word);
            failures++;
            return;
         end
         exp_acc = owed_verdicts.pop_front();
         if (exp_acc) n_accepted++;
         else n_rejected++;
         if (word[0] !== exp_acc) begin
            $error("accepted: expected %0b, actual %0b", exp_acc, word[0]);
            failures++;
         end
         if (word[7:1] !== 7'd0) begin
            $error("padding: expected 0, actual %h", word[7:1]);
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   verdict_scoreboard board = new();
   logic [7:0]        spec_bytes[$];
   int                bytes_sent = 0;
   int                burst_left = 0;
   int                n_strings  = 0;
   int                rcv_cycle  = 0;

   select_spec_syntax_check_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] text_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [0] accepted, [7:1] zero
   );

   // clock
   initial begin
      forever #5ns clock = ~clock;
   end

   // character pickers for the string builder
   function automatic logic [7:0] pick_alpha();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_name_char();
      case ($urandom_range(0, 3))
         0:       return pick_alpha();
         1:       return pick_digit();
         2:       return sssc_pkg::CH_DASH;
         default: return sssc_pkg::CH_USCORE;
      endcase
   endfunction

   // printable byte that does not steer the grammar
   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(8'h20, 8'h7E));
      while (b == sssc_pkg::CH_SQUOTE || b == sssc_pkg::CH_DQUOTE ||
             b == sssc_pkg::CH_COLON || b == sssc_pkg::CH_PLUS);
      return b;
   endfunction

   // name=value with plain and quoted runs, value possibly empty
   task automatic add_pair();
      logic [7:0] q;
      logic [7:0] b;
      spec_bytes.push_back(pick_alpha());
      repeat ($urandom_range(0, 3)) spec_bytes.push_back(pick_name_char());
      spec_bytes.push_back(sssc_pkg::CH_EQUAL);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 2) != 0) begin
            spec_bytes.push_back(pick_plain());
         end else begin
            q = $urandom_range(0, 1) ? sssc_pkg::CH_DQUOTE : sssc_pkg::CH_SQUOTE;
            spec_bytes.push_back(q);
            repeat ($urandom_range(0, 3)) begin
               do b = 8'($urandom_range(1, 255));
               while (b == q);
               spec_bytes.push_back(b);
            end
            spec_bytes.push_back(q);
         end
      end
   endtask

   // one string: mostly well formed, some corrupted, some raw noise
   task automatic build_spec();
      int n_chunks;
      int kind;
      int n_pairs;
      spec_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) spec_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) begin
            spec_bytes.push_back(($urandom_range(0, 5) == 5) ? 8'h20
                                                            : 8'h09 + 8'($urandom_range(0, 4)));
         end
         n_chunks = $urandom_range(1, 3);
         for (int c = 0; c < n_chunks; c++) begin
            if (c > 0) spec_bytes.push_back(sssc_pkg::CH_PLUS);
            // 0 multiplier alone, 1 multiplier and pairs, 2 pairs alone
            kind = $urandom_range(0, 2);
            if (kind != 2) repeat ($urandom_range(1, 3)) spec_bytes.push_back(pick_digit());
            if (kind == 1) spec_bytes.push_back(sssc_pkg::CH_COLON);
            if (kind != 0) begin
               n_pairs = $urandom_range(1, 3);
               for (int p = 0; p < n_pairs; p++) begin
                  if (p > 0) spec_bytes.push_back(sssc_pkg::CH_COLON);
                  add_pair();
               end
            end
         end
         // break a few: one byte replaced, or the tail cut off
         if ($urandom_range(0, 5) == 0) begin
            spec_bytes[$urandom_range(0, spec_bytes.size() - 1)] = 8'($urandom_range(1, 255));
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) if (spec_bytes.size() > 0) void'(spec_bytes.pop_back());
         end
      end
      spec_bytes.push_back(sssc_pkg::CH_END);
   endtask

   // offer one word and wait for the handshake
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock);
      while (!req_tready);
      board.note_byte(b);
   endtask

   // send the built string in bursts with random gaps
   task automatic send_spec();
      int gap;
      foreach (spec_bytes[i]) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
         end
         send_byte(spec_bytes[i]);
         burst_left--;
         bytes_sent++;
         if (spec_bytes[i] == sssc_pkg::CH_END) n_strings++;
      end
   endtask

   // receiver: ready pattern in segments, two long hold-offs
   initial begin
      int seg_left;
      int mode;
      seg_left = 0;
      mode     = 0;
      forever begin
         @(negedge clock);
         rcv_cycle++;
         if (rcv_cycle == 400 || rcv_cycle == 1200) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF - 1) @(negedge clock);
            rcv_cycle += HOLD_OFF - 1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 4) != 0);
               default: rsp_tready <= rcv_cycle[0];
            endcase
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
   end

   // run limit
   initial begin
      #1ms;
      $display("simulation failed");
      $finish;
   end

   // main sequence
   initial begin
      logic [7:0] directed[$];
      // empty string, whitespace and lone multiplier, trailing '=',
      // a high byte in a quoted run then a multiplier chunk,
      // latched rejection on a high byte, open double quote
      directed = '{8'h00,
                   8'h09, 8'h32, 8'h00,
                   8'h61, 8'h3D, 8'h00,
                   8'h78, 8'h3D, 8'h27, 8'hFF, 8'h27, 8'h2B, 8'h31, 8'h00,
                   8'hFF, 8'h61, 8'h00,
                   8'h33, 8'h3A, 8'h62, 8'h3D, 8'h22, 8'h00,
                   8'h20, 8'h00};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      spec_bytes = directed;
      send_spec();

      while (bytes_sent < TARGET_BYTES + directed.size()) begin
         build_spec();
         send_spec();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then allow for the pipeline latency
      while (board.owed_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d bytes forming %0d strings", bytes_sent, n_strings);
      $display("verdicts checked: %0d accepted, %0d rejected",
               board.n_accepted, board.n_rejected);
      if (board.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ select_spec_syntax_check_top.f @@
+incdir+rtl
rtl/sssc_pkg.sv
rtl/sssc_phase_step.sv
rtl/select_spec_syntax_check_top.sv
rtl/sssc_checker.sv
sim/select_spec_syntax_check_top_test.sv
